[rtl/core/spnbc_pkg.sv]
// Shared types, codes and constants for the SPN block cipher round engine.
// Holds the block mixing functions and the round mask tables.
// No dependencies.
package spnbc_pkg;

   localparam int BLK_W        = 128;
   localparam int BYTE_W       = 8;
   localparam int NIB_W        = 4;
   localparam int BLK_BYTES    = 16;
   localparam int PERM_ENTRIES = 32;
   localparam int PERM_IDX_W   = 5;
   localparam int SBOX_DEPTH   = 256;
   localparam int CFG_W        = 5;
   localparam int CSR_IDX_W    = 1;
   localparam int ROUND_SLOTS  = 17;
   localparam int PERIODS      = 32;

   localparam logic [CFG_W-1:0] RESET_ROUND_COUNT = 5'd16;
   localparam logic [CFG_W-1:0] RESET_PBOX_PERIOD = 5'd2;

   // Rounds 4, 8, 12 and 16 use the sliding XOR diffusion.
   localparam logic [ROUND_SLOTS-1:0] SLIDE_ROUND_MASK = 17'b1_0001_0001_0001_0000;

   typedef enum logic [2:0] {
      REQ_SUB_WR  = 3'd0,
      REQ_PERM_WR = 3'd1,
      REQ_KEY_WR  = 3'd2,
      REQ_ENCRYPT = 3'd3,
      REQ_DECRYPT = 3'd4
   } req_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROUND_COUNT = 1'b0,
      CSR_PBOX_PERIOD = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              sub_we;
      logic              perm_we;
      logic              key_we;
      logic [BYTE_W-1:0] index;
      logic [BYTE_W-1:0] value;
   } tbl_wr_type;

   typedef logic [ROUND_SLOTS-1:0]              round_mask_type;
   typedef logic [PERIODS-1:0][ROUND_SLOTS-1:0] period_mask_table_type;

   // Per period: the rounds that take the nibble permutation (multiples of the
   // period that are not multiples of four). Built at elaboration.
   function automatic period_mask_table_type build_period_masks();
      period_mask_table_type tab;
      int                    m;
      tab = '0;
      for (int p = 1; p < PERIODS; p++) begin
         m = p;
         while (m < ROUND_SLOTS) begin
            if ((m % 4) != 0) begin
               tab[p][m] = 1'b1;
            end
            m = m + p;
         end
      end
      return tab;
   endfunction

   localparam period_mask_table_type PERIOD_MASKS = build_period_masks();

   // Forward slide: byte i > 0 takes the running XOR of bytes 0..i; byte 0 takes the XOR of bytes 1..15.
   function automatic logic [BLK_W-1:0] slide_fwd(input logic [BLK_W-1:0] blk);
      logic [BLK_W-1:0]  res;
      logic [BYTE_W-1:0] acc;
      res = '0;
      for (int i = 0; i < BLK_BYTES; i++) begin
         acc = '0;
         for (int j = 0; j < BLK_BYTES; j++) begin
            if ((i == 0 && j != 0) || (i != 0 && j <= i)) begin
               acc = acc ^ blk[BLK_W-1-BYTE_W*j -: BYTE_W];
            end
         end
         res[BLK_W-1-BYTE_W*i -: BYTE_W] = acc;
      end
      return res;
   endfunction

   // Backward slide: undo the forward slide.
   function automatic logic [BLK_W-1:0] slide_bwd(input logic [BLK_W-1:0] blk);
      logic [BLK_W-1:0]  res;
      logic [BYTE_W-1:0] b0;
      b0 = blk[BLK_W-1 -: BYTE_W] ^ blk[BYTE_W-1:0];
      res = '0;
      res[BLK_W-1 -: BYTE_W] = b0;
      res[BLK_W-1-BYTE_W -: BYTE_W] = blk[BLK_W-1-BYTE_W -: BYTE_W] ^ b0;
      for (int i = 2; i < BLK_BYTES; i++) begin
         res[BLK_W-1-BYTE_W*i -: BYTE_W] = blk[BLK_W-1-BYTE_W*i -: BYTE_W]
                                         ^ blk[BLK_W-1-BYTE_W*(i-1) -: BYTE_W];
      end
      return res;
   endfunction

endpackage

[rtl/core/spnbc_sbox_bank.sv]
// Byte substitution memories: sixteen lanes, each with a forward and an
// inverse 256 x 8 table, written together and read one address per lane.
// Depends on spnbc_pkg.
module spnbc_sbox_bank
   import spnbc_pkg::*;
(
   input  logic             clock,
   input  tbl_wr_type       wr,
   input  logic             sub_rd_en,
   input  logic             inv_rd_en,
   input  logic [BLK_W-1:0] rd_addr,
   output logic [BLK_W-1:0] sub_data,
   output logic [BLK_W-1:0] inv_data
);

   for (genvar lane = 0; lane < BLK_BYTES; lane++) begin : g_lane
      logic [BYTE_W-1:0] sub_mem_ff [SBOX_DEPTH];
      logic [BYTE_W-1:0] inv_mem_ff [SBOX_DEPTH];
      logic [BYTE_W-1:0] sub_q_ff;
      logic [BYTE_W-1:0] inv_q_ff;
      logic [BYTE_W-1:0] lane_addr;

      assign lane_addr = rd_addr[BLK_W-1-BYTE_W*lane -: BYTE_W];

      always_ff @(posedge clock) begin
         if (wr.sub_we) begin
            sub_mem_ff[wr.index] <= wr.value;
         end
         if (sub_rd_en) begin
            sub_q_ff <= sub_mem_ff[lane_addr];
         end
      end

      // Inverse entry: value maps back to index.
      always_ff @(posedge clock) begin
         if (wr.sub_we) begin
            inv_mem_ff[wr.value] <= wr.index;
         end
         if (inv_rd_en) begin
            inv_q_ff <= inv_mem_ff[lane_addr];
         end
      end

      assign sub_data[BLK_W-1-BYTE_W*lane -: BYTE_W] = sub_q_ff;
      assign inv_data[BLK_W-1-BYTE_W*lane -: BYTE_W] = inv_q_ff;
   end

endmodule

[rtl/core/spnbc_key_bank.sv]
// Round key memory: sixteen byte lanes, one row of sixteen key bytes per
// round, read a full row per cycle. Depends on spnbc_pkg.
module spnbc_key_bank
   import spnbc_pkg::*;
#(
   parameter  int ROWS      = 16,
   localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                    clock,
   input  tbl_wr_type              wr,
   input  logic                    rd_en,
   input  logic [ROW_IDX_W-1:0]    rd_row,
   output logic [BLK_W-1:0]        key_data
);

   logic                 row_ok;
   logic [ROW_IDX_W-1:0] wr_row;

   // Key byte index splits into row (upper nibble) and lane (lower nibble).
   assign row_ok = {1'b0, wr.index[7:4]} < 5'(ROWS);
   assign wr_row = wr.index[4 +: ROW_IDX_W];

   for (genvar lane = 0; lane < BLK_BYTES; lane++) begin : g_lane
      logic [BYTE_W-1:0] key_mem_ff [ROWS];
      logic [BYTE_W-1:0] key_q_ff;
      logic              lane_we;

      assign lane_we = wr.key_we && row_ok && (wr.index[3:0] == 4'(lane));

      always_ff @(posedge clock) begin
         if (lane_we) begin
            key_mem_ff[wr_row] <= wr.value;
         end
         if (rd_en) begin
            key_q_ff <= key_mem_ff[rd_row];
         end
      end

      assign key_data[BLK_W-1-BYTE_W*lane -: BYTE_W] = key_q_ff;
   end

endmodule

[rtl/core/spnbc_perm_unit.sv]
// Nibble permutation: forward and inverse 32 x 5 tables in flops and the
// nibble scatter, where a later source wins and untargeted nibbles are zero.
// Depends on spnbc_pkg.
module spnbc_perm_unit
   import spnbc_pkg::*;
(
   input  logic             clock,
   input  tbl_wr_type       wr,
   input  logic             use_inverse,
   input  logic [BLK_W-1:0] blk_in,
   output logic [BLK_W-1:0] blk_out
);

   logic [PERM_IDX_W-1:0]   perm_ff [PERM_ENTRIES];
   logic [PERM_IDX_W-1:0]   inv_ff  [PERM_ENTRIES];
   logic [PERM_IDX_W-1:0]   tab     [PERM_ENTRIES];
   logic [NIB_W-1:0]        src     [PERM_ENTRIES];
   logic [PERM_ENTRIES-1:0] hit     [PERM_ENTRIES];
   logic                    wr_ok;

   // Drop writes whose index or value fall outside the table.
   assign wr_ok = wr.perm_we && (wr.index[7:5] == 3'd0) && (wr.value[7:5] == 3'd0);

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         perm_ff[wr.index[PERM_IDX_W-1:0]] <= wr.value[PERM_IDX_W-1:0];
         inv_ff[wr.value[PERM_IDX_W-1:0]]  <= wr.index[PERM_IDX_W-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < PERM_ENTRIES; i++) begin
         tab[i] = use_inverse ? inv_ff[i] : perm_ff[i];
         src[i] = blk_in[BLK_W-1-NIB_W*i -: NIB_W];
      end
   end

   // hit[j][i]: source nibble i targets destination nibble j
   always_comb begin
      for (int j = 0; j < PERM_ENTRIES; j++) begin
         for (int i = 0; i < PERM_ENTRIES; i++) begin
            hit[j][i] = (tab[i] == PERM_IDX_W'(j));
         end
      end
   end

   // Each destination takes its highest-numbered matching source.
   always_comb begin
      blk_out = '0;
      for (int j = 0; j < PERM_ENTRIES; j++) begin
         for (int i = 0; i < PERM_ENTRIES; i++) begin
            if (hit[j][i] && ((hit[j] >> (i + 1)) == '0)) begin
               blk_out[BLK_W-1-NIB_W*j -: NIB_W] = blk_out[BLK_W-1-NIB_W*j -: NIB_W] | src[i];
            end
         end
      end
   end

endmodule

[rtl/core/spn_block_cipher_rounds_top.sv]
// SPN block cipher round engine. Request channel (req_*, valid/stall) takes
// table writes and 128-bit encrypt/decrypt jobs; result channel (rsp_*,
// valid/stall) returns one block per cipher job; csr_* writes round_count
// (index 0) and pbox_period (index 1) and is always ready.
// Table writes (S-box, P-box, key byte) give no result; S-box and P-box
// writes also fill the matching inverse entry. Load all tables before use.
// round_count above MAX_ROUNDS counts as MAX_ROUNDS and zero rounds return
// the block unchanged.
// One round runs per cycle, set by the loop through the S-box memories:
// read address, registered read data, mix and key add, next read address.
// The engine works on one job at a time; req_stall is high while a job runs.
// A finished block waits in the output register; when rsp_stall holds it, the
// engine still takes the next request and holds that job's result until the
// output register frees up.
// Reset (synchronous) empties the output register and returns to idle; the
// tables and keys are not cleared and must be reloaded by software.
// Depends on spnbc_pkg and the sbox, key and perm submodules.
module spn_block_cipher_rounds_top
   import spnbc_pkg::*;
#(
   parameter int MAX_ROUNDS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_type,
   input  logic [BYTE_W-1:0]    req_table_index,
   input  logic [BYTE_W-1:0]    req_table_value,
   input  logic [63:0]          req_block_high,
   input  logic [63:0]          req_block_low,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [63:0]          rsp_result_high,
   output logic [63:0]          rsp_result_low,
   output logic                 rsp_result_kind,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   localparam int RND_W = $clog2(MAX_ROUNDS + 1);
   localparam int ROW_W = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
   localparam logic [MAX_ROUNDS:0] SLIDE_ROUNDS = SLIDE_ROUND_MASK[MAX_ROUNDS:0];

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_FLUSH = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [RND_W-1:0]    rnd_ff, rnd_in;
   logic [RND_W-1:0]    rounds_ff, rounds_in;
   logic                dir_ff, dir_in;
   logic                first_ff, first_in;
   logic [BLK_W-1:0]    blk_ff, blk_in;
   logic [MAX_ROUNDS:0] perm_mask_ff, perm_mask_in;
   logic [CFG_W-1:0]    round_count_ff;
   logic [CFG_W-1:0]    pbox_period_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [63:0]         rsp_high_ff, rsp_high_in;
   logic [63:0]         rsp_low_ff, rsp_low_in;
   logic                rsp_kind_ff, rsp_kind_in;

   logic                req_accept;
   logic                out_free;
   logic [RND_W-1:0]    rounds_eff;
   logic [RND_W-1:0]    rounds_m1;
   logic [RND_W-1:0]    dec_row;
   tbl_wr_type          wr;
   logic                sub_rd_en;
   logic                inv_rd_en;
   logic [BLK_W-1:0]    sbox_addr;
   logic                key_rd_en;
   logic [ROW_W-1:0]    key_row;
   logic [BLK_W-1:0]    sub_q;
   logic [BLK_W-1:0]    inv_q;
   logic [BLK_W-1:0]    key_q;
   logic [BLK_W-1:0]    perm_in;
   logic [BLK_W-1:0]    perm_out;
   logic                perm_now;
   logic                slide_now;
   logic [BLK_W-1:0]    enc_val;
   logic [BLK_W-1:0]    dec_cur;
   logic [BLK_W-1:0]    dec_x;
   logic [BLK_W-1:0]    dec_addr;

   spnbc_sbox_bank u_sbox (
      .clock     (clock),
      .wr        (wr),
      .sub_rd_en (sub_rd_en),
      .inv_rd_en (inv_rd_en),
      .rd_addr   (sbox_addr),
      .sub_data  (sub_q),
      .inv_data  (inv_q)
   );

   spnbc_key_bank #(
      .ROWS (MAX_ROUNDS)
   ) u_key (
      .clock    (clock),
      .wr       (wr),
      .rd_en    (key_rd_en),
      .rd_row   (key_row),
      .key_data (key_q)
   );

   spnbc_perm_unit u_perm (
      .clock       (clock),
      .wr          (wr),
      .use_inverse (dir_ff),
      .blk_in      (perm_in),
      .blk_out     (perm_out)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   assign rounds_eff = (round_count_ff > CFG_W'(MAX_ROUNDS)) ? RND_W'(MAX_ROUNDS)
                                                              : round_count_ff[RND_W-1:0];
   assign rounds_m1  = rounds_eff - RND_W'(1);
   assign dec_row    = rnd_ff - RND_W'(2);

   // Round datapath: encrypt mixes the S-box output then adds the key;
   // decrypt adds the key, unmixes, then feeds the inverse S-box.
   assign perm_now  = perm_mask_ff[rnd_ff];
   assign slide_now = SLIDE_ROUNDS[rnd_ff];
   assign dec_cur   = first_ff ? blk_ff : inv_q;
   assign dec_x     = dec_cur ^ key_q;
   assign perm_in   = dir_ff ? dec_x : sub_q;
   assign enc_val   = (perm_now ? perm_out : (slide_now ? slide_fwd(sub_q) : sub_q)) ^ key_q;
   assign dec_addr  = perm_now ? perm_out : (slide_now ? slide_bwd(dec_x) : dec_x);

   always_comb begin
      state_in     = state_ff;
      rnd_in       = rnd_ff;
      rounds_in    = rounds_ff;
      dir_in       = dir_ff;
      first_in     = first_ff;
      blk_in       = blk_ff;
      perm_mask_in = perm_mask_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_high_in  = rsp_high_ff;
      rsp_low_in   = rsp_low_ff;
      rsp_kind_in  = rsp_kind_ff;
      wr           = '0;
      wr.index     = req_table_index;
      wr.value     = req_table_value;
      sub_rd_en    = 1'b0;
      inv_rd_en    = 1'b0;
      sbox_addr    = enc_val;
      key_rd_en    = 1'b0;
      key_row      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_type)
                  REQ_SUB_WR:  wr.sub_we  = 1'b1;
                  REQ_PERM_WR: wr.perm_we = 1'b1;
                  REQ_KEY_WR:  wr.key_we  = 1'b1;
                  REQ_ENCRYPT: begin
                     dir_in       = 1'b0;
                     blk_in       = {req_block_high, req_block_low};
                     rounds_in    = rounds_eff;
                     perm_mask_in = PERIOD_MASKS[pbox_period_ff][MAX_ROUNDS:0];
                     if (rounds_eff == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        sub_rd_en = 1'b1;
                        sbox_addr = {req_block_high, req_block_low};
                        key_rd_en = 1'b1;
                        key_row   = '0;
                        rnd_in    = RND_W'(1);
                        state_in  = ST_RUN;
                     end
                  end
                  REQ_DECRYPT: begin
                     dir_in       = 1'b1;
                     blk_in       = {req_block_high, req_block_low};
                     rounds_in    = rounds_eff;
                     perm_mask_in = PERIOD_MASKS[pbox_period_ff][MAX_ROUNDS:0];
                     if (rounds_eff == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        // prefetch the last round's key row
                        key_rd_en = 1'b1;
                        key_row   = rounds_m1[ROW_W-1:0];
                        rnd_in    = rounds_eff;
                        first_in  = 1'b1;
                        state_in  = ST_RUN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            if (!dir_ff) begin
               if (rnd_ff == rounds_ff) begin
                  blk_in   = enc_val;
                  state_in = ST_DONE;
               end else begin
                  sub_rd_en = 1'b1;
                  sbox_addr = enc_val;
                  key_rd_en = 1'b1;
                  key_row   = rnd_ff[ROW_W-1:0];
                  rnd_in    = rnd_ff + RND_W'(1);
               end
            end else begin
               inv_rd_en = 1'b1;
               sbox_addr = dec_addr;
               first_in  = 1'b0;
               if (rnd_ff == RND_W'(1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  key_rd_en = 1'b1;
                  key_row   = dec_row[ROW_W-1:0];
                  rnd_in    = rnd_ff - RND_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            blk_in   = inv_q;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold the block until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_high_in  = blk_ff[BLK_W-1 -: 64];
               rsp_low_in   = blk_ff[63:0];
               rsp_kind_in  = dir_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rnd_ff       <= '0;
         dir_ff       <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         dir_ff       <= dir_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rounds_ff    <= rounds_in;
      blk_ff       <= blk_in;
      perm_mask_ff <= perm_mask_in;
      rsp_high_ff  <= rsp_high_in;
      rsp_low_ff   <= rsp_low_in;
      rsp_kind_ff  <= rsp_kind_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_count_ff <= RESET_ROUND_COUNT;
         pbox_period_ff <= RESET_PBOX_PERIOD;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROUND_COUNT: round_count_ff <= csr_data;
            CSR_PBOX_PERIOD: pbox_period_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_high = rsp_high_ff;
   assign rsp_result_low  = rsp_low_ff;
   assign rsp_result_kind = rsp_kind_ff;

   a_run_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (rnd_ff != '0) && (rnd_ff <= rounds_ff))
      else $error("round counter outside 1..rounds while running");

   a_enc_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && !dir_ff && (rnd_ff != rounds_ff)
      |=> (state_ff == ST_RUN) && (rnd_ff == $past(rnd_ff) + RND_W'(1)))
      else $error("encrypt round did not advance by one");

   a_flush_origin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH)
      |-> ($past(state_ff) == ST_RUN) && $past(dir_ff) && ($past(rnd_ff) == RND_W'(1)))
      else $error("flush entered other than after decrypt round one");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && !out_free |=> (state_ff == ST_DONE))
      else $error("finished block left while output register busy");

endmodule
